// ----- sv/hcm_pkg.sv -----
// ---------------------------------------------------------------------------
// hcm_pkg: shared types and constants for the heat map color unit
// Widths, pipeline depth, range modes and the restoring division step.
// ---------------------------------------------------------------------------
package hcm_pkg;

	// fraction bits of the normalized value t (1.0 = 2**FRAC_BITS)
	localparam int FRAC_BITS     = 8;
	localparam int SAMPLE_W      = 20;
	localparam int DEN_W         = 20;
	localparam int CH_W          = 8;
	localparam int IN_TDATA_W    = 24;
	localparam int OUT_TDATA_W   = 24;
	localparam int CFG_IDX_W     = 1;
	// division steps done in one pipeline stage
	localparam int DIV_PER_STAGE = 2;
	localparam int DIV_STAGES    = (FRAC_BITS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE = 1'd1;

	// how t is formed for one sample
	typedef enum logic [1:0] {
		MODE_ZERO,
		MODE_ONE,
		MODE_DIV
	} mode_t;

	// one restoring division step; rem < den on entry and on exit
	// result: quotient bit in the MSB, new remainder below it
	function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
		input logic [DEN_W-1:0] den);
		logic [DEN_W:0] dbl;
		logic [DEN_W:0] diff;
		dbl  = {rem, 1'b0};
		diff = dbl - {1'b0, den};
		if (dbl >= {1'b0, den}) begin
			div_step = {1'b1, diff[DEN_W-1:0]};
		end else begin
			div_step = {1'b0, dbl[DEN_W-1:0]};
		end
	endfunction

endpackage

// ----- sv/heatmap_color_map_unit.sv -----
// Path from input beat to output beat: the input stage, the division stages
// and the output register. Throughput: one sample per cycle while the output
// is not stalled; the quotient of t comes from a pipelined restoring divider,
// two quotient bits per stage. A stall at the output holds every stage; the
// input is ready whenever the output register is empty or being drained.
// Reset clears all stage valid bits and sets min_value and max_value to 0.
// ---------------------------------------------------------------------------
// heatmap_color_map_unit: blue to red false-color pixel from a scalar sample
// Normalizes the sample against the configured range, then maps the hue
// piecewise through cyan, green and yellow.
// ---------------------------------------------------------------------------
module heatmap_color_map_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [hcm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hcm_pkg::SAMPLE_W-1:0]      cfg_data,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [hcm_pkg::IN_TDATA_W-1:0]    s_tdata,  // [19:0] sample, [23:20] zero
	// output stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [hcm_pkg::OUT_TDATA_W-1:0]   m_tdata   // [7:0] red, [15:8] green, [23:16] blue
);
	import hcm_pkg::*;

	localparam logic [FRAC_BITS:0] T_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

	logic signed [SAMPLE_W-1:0] min_value_q;
	logic signed [SAMPLE_W-1:0] max_value_q;

	logic en;
	logic signed [SAMPLE_W-1:0] sample;
	logic signed [SAMPLE_W:0]   num_wide;
	logic signed [SAMPLE_W:0]   den_wide;
	mode_t                      mode_in;

	// stage arrays: index 0 is the input stage, index k+1 follows division stage k
	logic             valid_s [0:DIV_STAGES];
	logic [DEN_W-1:0] rem_s   [0:DIV_STAGES];
	logic [DEN_W-1:0] den_s   [0:DIV_STAGES];
	logic [FRAC_BITS-1:0] quo_s [0:DIV_STAGES];
	mode_t            mode_s  [0:DIV_STAGES];

	logic [FRAC_BITS:0]   t_val;
	logic [FRAC_BITS:0]   s_val;
	logic [FRAC_BITS+2:0] h_val;
	logic [2:0]           seg;
	logic [FRAC_BITS-1:0] f_val;
	logic [CH_W-1:0]      f8;
	logic [CH_W-1:0]      q8;
	logic [CH_W-1:0]      red_d, green_d, blue_d;
	logic                 out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	// pipeline advances when the output register is free or drained
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_value_q <= '0;
			max_value_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_VALUE: min_value_q <= cfg_data;
				REG_MAX_VALUE: max_value_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage: range checks and the divider operands
	assign sample   = s_tdata[SAMPLE_W-1:0];
	assign num_wide = {sample[SAMPLE_W-1], sample} - {min_value_q[SAMPLE_W-1], min_value_q};
	assign den_wide = {max_value_q[SAMPLE_W-1], max_value_q}
		- {min_value_q[SAMPLE_W-1], min_value_q};

	always_comb begin
		priority if (max_value_q <= min_value_q) begin
			mode_in = MODE_ZERO;
		end else if (sample <= min_value_q) begin
			mode_in = MODE_ZERO;
		end else if (sample >= max_value_q) begin
			mode_in = MODE_ONE;
		end else begin
			mode_in = MODE_DIV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= num_wide[DEN_W-1:0];
			den_s[0]  <= den_wide[DEN_W-1:0];
			quo_s[0]  <= '0;
			mode_s[0] <= mode_in;
		end
	end

	// division stages, DIV_PER_STAGE quotient bits each
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic [DEN_W-1:0]     rem_d;
		logic [FRAC_BITS-1:0] quo_d;

		always_comb begin
			logic [DEN_W:0] step;
			rem_d = rem_s[k];
			quo_d = quo_s[k];
			for (int j = 0; j < DIV_PER_STAGE; j++) begin
				if (k * DIV_PER_STAGE + j < FRAC_BITS) begin
					step  = div_step(rem_d, den_s[k]);
					rem_d = step[DEN_W-1:0];
					quo_d = {quo_d[FRAC_BITS-2:0], step[DEN_W]};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= rem_d;
				den_s[k+1]  <= den_s[k];
				quo_s[k+1]  <= quo_d;
				mode_s[k+1] <= mode_s[k];
			end
		end
	end

	// color stage: t, segment and ramp values
	always_comb begin
		unique case (mode_s[DIV_STAGES])
			MODE_ZERO: t_val = '0;
			MODE_ONE:  t_val = T_ONE;
			MODE_DIV:  t_val = {1'b0, quo_s[DIV_STAGES]};
			default:   t_val = '0;
		endcase
	end

	assign s_val = T_ONE - t_val;
	assign h_val = {s_val, 2'b00};
	assign seg   = h_val[FRAC_BITS+2:FRAC_BITS];
	assign f_val = h_val[FRAC_BITS-1:0];
	assign f8    = CH_W'(({f_val, {CH_W{1'b0}}}) >> FRAC_BITS);
	assign q8    = {CH_W{1'b1}} - f8;

	always_comb begin
		unique case (seg)
			3'd0: begin red_d = '1; green_d = f8; blue_d = '0; end
			3'd1: begin red_d = q8; green_d = '1; blue_d = '0; end
			3'd2: begin red_d = '0; green_d = '1; blue_d = f8; end
			3'd3: begin red_d = '0; green_d = q8; blue_d = '1; end
			default: begin red_d = f8; green_d = '0; blue_d = '1; end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {blue_d, green_d, red_d};
		end
	end

`ifndef SYNTH
	// divider remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[DIV_STAGES] && mode_s[DIV_STAGES] == MODE_DIV
		|-> rem_s[DIV_STAGES] < den_s[DIV_STAGES])
		else $error("divider remainder not below divisor");

	// sample at or above the range gives pure red
	a_full_red: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s[DIV_STAGES] && mode_s[DIV_STAGES] == MODE_ONE
		|=> m_tvalid && m_tdata == 24'h0000FF)
		else $error("top of range is not pure red");

	// sample at or below the range, or empty range, gives pure blue
	a_full_blue: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s[DIV_STAGES] && mode_s[DIV_STAGES] == MODE_ZERO
		|=> m_tvalid && m_tdata == 24'hFF0000)
		else $error("bottom of range is not pure blue");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// ---------------------------------------------------------------------------
// tb: self-checking bench for heatmap_color_map_unit
// Samples stream in over the slave side while the min/max range is set up
// through the write port. Each accepted sample is turned into its expected
// pixel by a bit-exact model kept in a small scoreboard class. Pixels leaving
// the master side are checked in order, channel by channel. Phases change the
// range (empty, inverted, tiny, full scale) and the sender and receiver
// idling patterns.
// ---------------------------------------------------------------------------
module tb;
	import hcm_pkg::*;

	localparam int PIPE_LATENCY = DIV_STAGES + 2;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_BEATS  = 75;
	localparam longint SAMPLE_MIN = -524288;
	localparam longint SAMPLE_MAX = 524287;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} rgb_t;

	// Scoreboard: holds the range copy and the pixels still owed by the block
	class pixel_checker_t;
		longint lo_bound;
		longint hi_bound;
		rgb_t   pending_pixels[$];
		int     errors;

		function new();
			lo_bound = 0;
			hi_bound = 0;
			errors   = 0;
		endfunction

		function void set_range(longint lo, longint hi);
			lo_bound = lo;
			hi_bound = hi;
		endfunction

		function int pending();
			return pending_pixels.size();
		endfunction

		// normalize, then walk the hue from blue (t = 0) to red (t = 1)
		function rgb_t heat_color(longint v);
			longint one;
			longint t;
			longint h;
			longint seg;
			longint f8;
			longint q8;
			rgb_t   px;
			one = longint'(1) << FRAC_BITS;
			t   = 0;
			if (hi_bound > lo_bound) begin
				if (v <= lo_bound) begin
					t = 0;
				end else if (v >= hi_bound) begin
					t = one;
				end else begin
					t = ((v - lo_bound) << FRAC_BITS) / (hi_bound - lo_bound);
					if (t > one)
						t = one;
				end
			end
			h   = (one - t) * 4;
			seg = h >> FRAC_BITS;
			f8  = (((h & (one - 1)) << 8) >> FRAC_BITS) & 255;
			q8  = 255 - f8;
			case (seg)
				0: begin
					px.red = 8'd255; px.green = f8[7:0]; px.blue = 8'd0;
				end
				1: begin
					px.red = q8[7:0]; px.green = 8'd255; px.blue = 8'd0;
				end
				2: begin
					px.red = 8'd0; px.green = 8'd255; px.blue = f8[7:0];
				end
				3: begin
					px.red = 8'd0; px.green = q8[7:0]; px.blue = 8'd255;
				end
				default: begin
					px.red = f8[7:0]; px.green = 8'd0; px.blue = 8'd255;
				end
			endcase
			return px;
		endfunction

		function void note_sample(logic signed [SAMPLE_W-1:0] v);
			pending_pixels.insert(pending_pixels.size(), heat_color(longint'(v)));
		endfunction

		task report(string msg);
			errors++;
			$display("MISMATCH: %s", msg);
		endtask

		task check_pixel(logic [OUT_TDATA_W-1:0] word);
			rgb_t want;
			rgb_t got;
			got = word;
			if (pending_pixels.size() == 0) begin
				report($sformatf("pixel %h with no sample waiting", word));
			end else begin
				want = pending_pixels.pop_front();
				if (got.red !== want.red)
					report($sformatf("red %0d, want %0d", got.red, want.red));
				if (got.green !== want.green)
					report($sformatf("green %0d, want %0d", got.green, want.green));
				if (got.blue !== want.blue)
					report($sformatf("blue %0d, want %0d", got.blue, want.blue));
			end
		endtask
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [SAMPLE_W-1:0]        cfg_data;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [IN_TDATA_W-1:0]      s_tdata;  // [19:0] sample, [23:20] zero
	logic                       m_tvalid;
	logic                       m_tready;
	logic [OUT_TDATA_W-1:0]     m_tdata;  // [7:0] red, [15:8] green, [23:16] blue

	pixel_checker_t sb = new();
	int send_idle_pct;
	int stall_pct;

	heatmap_color_map_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// output side back-pressure
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// pixel monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_pixel(m_tdata);
	end

	// run limit
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("heatmap_color_map_unit test failed");
		$finish;
	end

	task set_idling(idle_mode_t mode);
		send_idle_pct = (mode == IDLE_SENDER || mode == IDLE_BOTH) ?
			((mode == IDLE_BOTH) ? 18 : 68) : 0;
		stall_pct     = (mode == IDLE_RECEIVER || mode == IDLE_BOTH) ?
			((mode == IDLE_BOTH) ? 18 : 68) : 0;
	endtask

	// entered and left at a falling edge
	task write_range(longint lo, longint hi);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MIN_VALUE;
		cfg_data  <= lo[SAMPLE_W-1:0];
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MAX_VALUE;
		cfg_data  <= hi[SAMPLE_W-1:0];
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.set_range(lo, hi);
	endtask

	// one sample beat, with random idle cycles in front of it
	task drive_sample(longint v);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W-SAMPLE_W){1'b0}}, v[SAMPLE_W-1:0]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_sample(v[SAMPLE_W-1:0]);
		@(negedge clk);
	endtask

	task wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (PIPE_LATENCY + 2) @(negedge clk);
	endtask

	// mostly samples around and inside the range, some anywhere
	function automatic longint pick_sample(longint lo, longint hi);
		longint a;
		longint b;
		longint v;
		int     pick;
		a    = (lo < hi) ? lo : hi;
		b    = (lo < hi) ? hi : lo;
		pick = $urandom_range(99);
		if (pick < 55)
			v = a + longint'($urandom_range(int'(b - a)));
		else if (pick < 70)
			v = (pick < 62) ? a + longint'($urandom_range(2)) - 1 :
				b + longint'($urandom_range(2)) - 1;
		else
			v = longint'($signed($urandom_range(32'hFFFFF) << 12)) >>> 12;
		if (v < SAMPLE_MIN)
			v = SAMPLE_MIN;
		if (v > SAMPLE_MAX)
			v = SAMPLE_MAX;
		return v;
	endfunction

	longint range_lo[8] = '{SAMPLE_MIN, 0, 5, 300, SAMPLE_MAX, SAMPLE_MIN, 100000, 10};
	longint range_hi[8] = '{SAMPLE_MAX, 255, 6, -300, SAMPLE_MAX, -524000, SAMPLE_MAX, 13};
	longint directed[15] = '{0, 1024, -1, 1025, 128, 256, 257, 384, 512, 640,
		768, 896, 1023, 1, 4};

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_MIN_VALUE;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		set_idling(IDLE_NONE);
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty range after reset: everything is blue
		drive_sample(SAMPLE_MIN);
		drive_sample(SAMPLE_MAX);
		drive_sample(0);
		wait_drained();

		// full-scale range, extremes and mid-scale
		write_range(SAMPLE_MIN, SAMPLE_MAX);
		drive_sample(SAMPLE_MIN);
		drive_sample(SAMPLE_MAX);
		drive_sample(-1);
		drive_sample(0);
		wait_drained();

		// 0..1024: segment edges, clamps and truncation of t
		write_range(0, 1024);
		foreach (directed[k])
			drive_sample(directed[k]);
		wait_drained();

		// random phases over several ranges and idling patterns
		for (int p = 0; p < 8; p++) begin
			write_range(range_lo[p], range_hi[p]);
			set_idling(idle_mode_t'(p % 4));
			repeat (PHASE_BEATS)
				drive_sample(pick_sample(range_lo[p], range_hi[p]));
			wait_drained();
		end

		if (sb.pending() != 0)
			sb.report($sformatf("%0d pixels never arrived", sb.pending()));
		if (sb.errors == 0) begin
			$display("heatmap_color_map_unit test passed");
		end else begin
			$display("heatmap_color_map_unit test failed");
		end
		$finish;
	end

endmodule
